[hw/rtl/array_list_engine_core_assert.svh]
// Assertion macros used by the list engine controller.
`ifndef ARRAY_LIST_ENGINE_CORE_ASSERT_SVH
`define ARRAY_LIST_ENGINE_CORE_ASSERT_SVH

// Same-cycle implication under synchronous reset.
`define ALEC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication under synchronous reset.
`define ALEC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/alec_pkg.sv]
package alec_pkg;

  typedef logic [2:0]        op_t;
  typedef logic [1:0]        status_t;
  typedef logic signed [31:0] value_t;
  typedef logic [3:0]        pos_t;
  typedef logic [4:0]        count_t;

  localparam op_t OP_APPEND      = 3'd0;
  localparam op_t OP_INSERT      = 3'd1;
  localparam op_t OP_REMOVE_LAST = 3'd2;
  localparam op_t OP_REMOVE_AT   = 3'd3;
  localparam op_t OP_SEARCH      = 3'd4;

  localparam status_t ST_OK     = 2'd0;
  localparam status_t ST_FULL   = 2'd1;
  localparam status_t ST_EMPTY  = 2'd2;
  localparam status_t ST_BADPOS = 2'd3;

endpackage

[hw/rtl/alec_ram.sv]
module alec_ram #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  alec_pkg::value_t wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output alec_pkg::value_t rdata
);
  import alec_pkg::*;

  value_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[hw/rtl/alec_ctrl.sv]
module alec_ctrl #(
  parameter int CAPACITY = 16,
  parameter int AW       = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  alec_pkg::op_t     operation,
  input  alec_pkg::value_t  value,
  input  alec_pkg::pos_t    position,
  output logic              done,
  output alec_pkg::status_t status,
  output logic              found,
  output alec_pkg::pos_t    found_index,
  output alec_pkg::count_t  count,
  output logic              we,
  output logic [AW-1:0]     waddr,
  output alec_pkg::value_t  wdata,
  output logic              re,
  output logic [AW-1:0]     raddr,
  input  alec_pkg::value_t  rdata
);
  import alec_pkg::*;

  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int CMPW = (CW > 4) ? CW : 4;
  localparam int OW   = (CW > 5) ? CW : 5;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_RUN   = 2'd1;
  localparam logic [1:0] S_FLUSH = 2'd2;
  localparam logic [1:0] S_FINAL = 2'd3;

  logic [1:0]    state;
  logic [CW-1:0] cnt;
  logic [AW-1:0] ptr;
  logic [AW-1:0] prv;
  logic [AW-1:0] pos_r;
  logic          vld;
  op_t           op_r;
  value_t        val_r;

  logic            accept;
  logic            full;
  logic            empty;
  logic [CW-1:0]   cnt_m1;
  logic [CMPW-1:0] pos_e;
  logic [CMPW-1:0] cnt_e;
  logic [CMPW-1:0] prv_e;
  logic [OW-1:0]   cnt_o;
  logic [AW-1:0]   pos_idx;
  logic [AW-1:0]   cnt_idx;
  logic            match;
  logic            last;

  assign busy    = (state != S_IDLE);
  assign accept  = start && (state == S_IDLE);
  assign full    = (cnt == CW'(CAPACITY));
  assign empty   = (cnt == '0);
  assign cnt_m1  = cnt - CW'(1);
  assign pos_e   = CMPW'(position);
  assign cnt_e   = CMPW'(cnt);
  assign prv_e   = CMPW'(prv);
  assign cnt_o   = OW'(cnt);
  assign pos_idx = pos_e[AW-1:0];
  assign cnt_idx = cnt_e[AW-1:0];
  assign match   = vld && (rdata == val_r);
  assign last    = (op_r == OP_INSERT) ? (ptr == pos_r) : (ptr == cnt_m1[AW-1:0]);
  assign count   = cnt_o[4:0];

  always_comb begin
    we    = 1'b0;
    waddr = (op_r == OP_INSERT) ? prv + AW'(1) : prv - AW'(1);
    wdata = rdata;
    re    = 1'b0;
    raddr = ptr;
    case (state)
      S_IDLE: begin
        if (accept && !full && (operation == OP_APPEND ||
            (operation == OP_INSERT && pos_e == cnt_e))) begin
          we    = 1'b1;
          waddr = cnt_idx;
          wdata = value;
        end
      end
      S_RUN: begin
        re = 1'b1;
        we = vld && (op_r != OP_SEARCH);
      end
      S_FLUSH: begin
        we = op_r != OP_SEARCH;
      end
      S_FINAL: begin
        we    = 1'b1;
        waddr = pos_r;
        wdata = val_r;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
      done  <= 1'b0;
      vld   <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          vld <= 1'b0;
          if (accept) begin
            op_r        <= operation;
            val_r       <= value;
            pos_r       <= pos_idx;
            status      <= ST_OK;
            found       <= 1'b0;
            found_index <= '0;
            done        <= 1'b1;
            case (operation)
              OP_APPEND: begin
                if (full) begin
                  status <= ST_FULL;
                end else begin
                  cnt <= cnt + CW'(1);
                end
              end
              OP_INSERT: begin
                if (full) begin
                  status <= ST_FULL;
                end else if (pos_e > cnt_e) begin
                  status <= ST_BADPOS;
                end else if (pos_e == cnt_e) begin
                  cnt <= cnt + CW'(1);
                end else begin
                  done  <= 1'b0;
                  ptr   <= cnt_m1[AW-1:0];
                  state <= S_RUN;
                end
              end
              OP_REMOVE_LAST: begin
                if (empty) begin
                  status <= ST_EMPTY;
                end else begin
                  cnt <= cnt_m1;
                end
              end
              OP_REMOVE_AT: begin
                if (empty) begin
                  status <= ST_EMPTY;
                end else if (pos_e >= cnt_e) begin
                  status <= ST_BADPOS;
                end else if (pos_e == CMPW'(cnt_m1)) begin
                  cnt <= cnt_m1;
                end else begin
                  done  <= 1'b0;
                  ptr   <= pos_idx + AW'(1);
                  state <= S_RUN;
                end
              end
              OP_SEARCH: begin
                if (!empty) begin
                  done  <= 1'b0;
                  ptr   <= '0;
                  state <= S_RUN;
                end
              end
              default: begin
                status <= ST_OK;
              end
            endcase
          end
        end
        S_RUN: begin
          vld <= 1'b1;
          prv <= ptr;
          if (op_r == OP_SEARCH && match) begin
            found       <= 1'b1;
            found_index <= prv_e[3:0];
            done        <= 1'b1;
            state       <= S_IDLE;
          end else if (last) begin
            state <= S_FLUSH;
          end else if (op_r == OP_INSERT) begin
            ptr <= ptr - AW'(1);
          end else begin
            ptr <= ptr + AW'(1);
          end
        end
        S_FLUSH: begin
          vld <= 1'b0;
          if (op_r == OP_INSERT) begin
            state <= S_FINAL;
          end else begin
            if (op_r == OP_SEARCH) begin
              found       <= match;
              found_index <= match ? prv_e[3:0] : '0;
            end else begin
              cnt <= cnt_m1;
            end
            done  <= 1'b1;
            state <= S_IDLE;
          end
        end
        S_FINAL: begin
          cnt   <= cnt + CW'(1);
          done  <= 1'b1;
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `include "array_list_engine_core_assert.svh"

  `ALEC_ASSERT_NOW(a_done_idle, clk, rst, done, !busy, "result strobe while walk in progress")
  `ALEC_ASSERT_NOW(a_ram_port, clk, rst, we && re, waddr != raddr, "read and write hit one entry")
  `ALEC_ASSERT_NOW(a_cnt_upd, clk, rst, !$past(rst) && !$stable(cnt), done, "count moved without result")
  `ALEC_ASSERT_NEXT(a_acc_next, clk, rst, accept, busy || done, "accepted word left no trace")

endmodule

[hw/rtl/array_list_engine_core.sv]
// Ordered list of up to CAPACITY signed 32-bit words held in a one-port-write,
// one-port-read synchronous RAM. Pulse start while busy is low to issue one
// operation; exactly one result follows, valid only in the cycle that done is
// high, and it must be captured then since there is no way to hold it.
// Append, remove-last, every error case, insert at the count, remove-at of the
// last entry and search of an empty list answer in the cycle after start. Any
// other insert-at shifts entries up from the end and remove-at shifts them down,
// one RAM entry moved per cycle; search reads from entry 0, one RAM read
// compared per cycle, stopping at the first match. busy stays high for the
// whole walk through the RAM.
module array_list_engine_core #(
  parameter int CAPACITY = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  alec_pkg::op_t     operation,
  input  alec_pkg::value_t  value,
  input  alec_pkg::pos_t    position,
  output logic              done,
  output alec_pkg::status_t status,
  output logic              found,
  output alec_pkg::pos_t    found_index,
  output alec_pkg::count_t  count
);
  import alec_pkg::*;

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  logic          we;
  logic [AW-1:0] waddr;
  value_t        wdata;
  logic          re;
  logic [AW-1:0] raddr;
  value_t        rdata;

  alec_ctrl #(
    .CAPACITY(CAPACITY),
    .AW      (AW)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .operation  (operation),
    .value      (value),
    .position   (position),
    .done       (done),
    .status     (status),
    .found      (found),
    .found_index(found_index),
    .count      (count),
    .we         (we),
    .waddr      (waddr),
    .wdata      (wdata),
    .re         (re),
    .raddr      (raddr),
    .rdata      (rdata)
  );

  alec_ram #(
    .DEPTH(CAPACITY),
    .AW   (AW)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .re   (re),
    .raddr(raddr),
    .rdata(rdata)
  );

endmodule

[tb/tb_top.sv]
module tb_top;
  import alec_pkg::*;

  localparam int LIST_CAP = 16;
  localparam int RANDOM_WORDS = 420;

  typedef struct {
    status_t status;
    logic    found;
    pos_t    found_index;
    count_t  count;
  } list_result_t;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    start = 1'b0;
  op_t     operation = OP_APPEND;
  value_t  value = '0;
  pos_t    position = '0;
  logic    busy;
  logic    done;
  status_t status;
  logic    found;
  pos_t    found_index;
  count_t  count;

  value_t       list_store [LIST_CAP];
  count_t       list_len = '0;
  list_result_t pending_results [$];
  int           mismatch_count = 0;
  int           max_gap = 6;

  array_list_engine_core #(
    .CAPACITY(LIST_CAP)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .operation(operation),
    .value(value),
    .position(position),
    .done(done),
    .status(status),
    .found(found),
    .found_index(found_index),
    .count(count)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic list_result_t apply_list_op(op_t op, value_t val, pos_t pos);
    list_result_t r;
    int i;
    r = '{ST_OK, 1'b0, 4'd0, 5'd0};
    case (op)
      OP_APPEND: begin
        if (list_len >= LIST_CAP) begin
          r.status = ST_FULL;
        end else begin
          list_store[list_len[3:0]] = val;
          list_len++;
        end
      end
      OP_INSERT: begin
        if (list_len >= LIST_CAP) begin
          r.status = ST_FULL;
        end else if (pos > list_len) begin
          r.status = ST_BADPOS;
        end else begin
          for (i = int'(list_len); i > int'(pos); i--) list_store[i] = list_store[i-1];
          list_store[pos] = val;
          list_len++;
        end
      end
      OP_REMOVE_LAST: begin
        if (list_len == 0) r.status = ST_EMPTY;
        else list_len--;
      end
      OP_REMOVE_AT: begin
        if (list_len == 0) begin
          r.status = ST_EMPTY;
        end else if (pos >= list_len) begin
          r.status = ST_BADPOS;
        end else begin
          for (i = int'(pos); i + 1 < int'(list_len); i++) list_store[i] = list_store[i+1];
          list_len--;
        end
      end
      OP_SEARCH: begin
        for (i = 0; i < int'(list_len); i++) begin
          if (!r.found && list_store[i] == val) begin
            r.found = 1'b1;
            r.found_index = pos_t'(i);
          end
        end
      end
      default: begin
      end
    endcase
    r.count = list_len;
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    mismatch_count++;
  endtask

  // hold start until the word is taken, then predict its result
  task automatic send_word(op_t op, value_t val, pos_t pos);
    int gap;
    gap = $urandom_range(0, max_gap);
    @(negedge clk);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start <= 1'b1;
    operation <= op;
    value <= val;
    position <= pos;
    do @(posedge clk); while (busy);
    pending_results.push_back(apply_list_op(op, val, pos));
  endtask

  task automatic wait_results_drained();
    @(negedge clk);
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  always @(posedge clk) begin
    list_result_t want;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected word, count", count, -1);
      end else begin
        want = pending_results.pop_front();
        if (status !== want.status) report_mismatch("status", status, want.status);
        if (found !== want.found) report_mismatch("found", found, want.found);
        if (found_index !== want.found_index)
          report_mismatch("found_index", found_index, want.found_index);
        if (count !== want.count) report_mismatch("count", count, want.count);
      end
    end
  end

  task automatic test_empty_list();
    send_word(OP_REMOVE_LAST, 32'sd5, 4'd0);
    send_word(OP_REMOVE_AT, 32'sd5, 4'd0);
    send_word(OP_SEARCH, 32'sd0, 4'd0);
    send_word(OP_INSERT, 32'sd9, 4'd3);
    send_word(op_t'(3'd7), -32'sd1, 4'hF);
  endtask

  task automatic test_edge_values();
    send_word(OP_INSERT, 32'sd0, 4'd0);
    send_word(OP_APPEND, 32'sh7FFF_FFFF, 4'hF);
    send_word(OP_INSERT, 32'sh8000_0000, 4'd0);
    send_word(OP_INSERT, -32'sd1, 4'd3);
    send_word(OP_INSERT, 32'sd0, 4'd2);
    send_word(OP_SEARCH, 32'sh8000_0000, 4'd0);
    send_word(OP_SEARCH, 32'sh7FFF_FFFF, 4'd0);
    send_word(OP_SEARCH, -32'sd1, 4'd0);
    send_word(OP_SEARCH, 32'sd0, 4'd0);
    send_word(OP_SEARCH, 32'sd12345, 4'd0);
    send_word(OP_REMOVE_AT, 32'sd0, 4'd5);
    send_word(OP_INSERT, 32'sd1, 4'd9);
    send_word(OP_REMOVE_AT, 32'sd0, 4'd1);
    send_word(op_t'(3'd5), 32'sd0, 4'd0);
    send_word(op_t'(3'd6), 32'sd0, 4'd0);
  endtask

  task automatic test_full_list();
    while (list_len < LIST_CAP)
      send_word(OP_INSERT, value_t'($urandom), pos_t'($urandom_range(0, list_len)));
    send_word(OP_APPEND, 32'sd1, 4'd0);
    send_word(OP_INSERT, 32'sd1, 4'd0);
    send_word(OP_SEARCH, list_store[LIST_CAP-1], 4'd0);
    send_word(OP_REMOVE_AT, 32'sd0, 4'd15);
    send_word(OP_INSERT, 32'sd77, 4'd15);
    send_word(OP_REMOVE_AT, 32'sd0, 4'd0);
    send_word(OP_REMOVE_LAST, 32'sd0, 4'd0);
    wait_results_drained();
  endtask

  function automatic value_t pick_value();
    case ($urandom_range(0, 7))
      0: return 32'sh8000_0000;
      1: return 32'sh7FFF_FFFF;
      2: return value_t'($urandom_range(0, 3));
      3: return -32'sd1;
      default: return value_t'($urandom);
    endcase
  endfunction

  function automatic op_t pick_op(int mode);
    int weights [3][5] = '{'{35, 35, 5, 10, 12}, '{8, 10, 25, 30, 24}, '{18, 20, 12, 18, 29}};
    int roll;
    int k;
    roll = $urandom_range(0, 99);
    for (k = 0; k < 5; k++) begin
      if (roll < weights[mode][k]) return op_t'(k);
      roll -= weights[mode][k];
    end
    return op_t'($urandom_range(5, 7));
  endfunction

  task automatic test_random_ops();
    int n;
    int mode;
    op_t op;
    value_t val;
    pos_t pos;
    mode = 0;
    for (n = 0; n < RANDOM_WORDS; n++) begin
      if (n % 40 == 0) begin
        mode = $urandom_range(0, 2);
        max_gap = ($urandom_range(0, 3) == 0) ? 0 : 6;
      end
      if (n % 100 == 99) wait_results_drained();
      op = pick_op(mode);
      val = pick_value();
      if (op == OP_SEARCH && list_len != 0 && $urandom_range(0, 9) < 6)
        val = list_store[pos_t'($urandom_range(0, list_len - 1))];
      if ($urandom_range(0, 4) == 0) pos = pos_t'($urandom);
      else if (op == OP_INSERT) pos = pos_t'($urandom_range(0, list_len));
      else if (list_len != 0) pos = pos_t'($urandom_range(0, list_len - 1));
      else pos = pos_t'($urandom);
      send_word(op, val, pos);
    end
    max_gap = 6;
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_empty_list();
    test_edge_values();
    test_full_list();
    test_random_ops();
    wait_results_drained();
    repeat (20) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("timeout with %0d results outstanding", pending_results.size());
    $display("Some tests failed");
    $finish;
  end

endmodule

[files.f]
+incdir+hw/rtl
hw/rtl/alec_pkg.sv
hw/rtl/alec_ram.sv
hw/rtl/alec_ctrl.sv
hw/rtl/array_list_engine_core.sv
tb/tb_top.sv
